// ===== src/ipmfb_pkg.sv =====
package ipmfb_pkg;

	// Store sizes.
	localparam int FB_BYTES     = 65536;
	localparam int PALETTE_SIZE = 256;
	localparam int FB_ADDR_W    = $clog2(FB_BYTES);
	localparam int PAL_ADDR_W   = $clog2(PALETTE_SIZE);

	// Signed width of canvas coordinates and of the byte address before the range check.
	localparam int COORD_W = 14;
	localparam int ADDR_W  = 24;

	// Queue between the address front and the read-modify-write back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Item kinds.
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_PIXEL = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] REG_ORIGIN_X     = 2'd0;
	localparam logic [1:0] REG_ORIGIN_Y     = 2'd1;
	localparam logic [1:0] REG_ROW_BYTES    = 2'd2;
	localparam logic [1:0] REG_SCREEN_WIDTH = 2'd3;

	// What the back has to do with a classified item.
	typedef enum logic [1:0] {
		OP_SKIP,
		OP_LOAD,
		OP_DRAW,
		OP_FAULT
	} op_t;

	typedef struct packed {
		logic        mode;
		logic [7:0]  entry_index;
		logic [15:0] entry_color;
		logic [7:0]  pixel_value;
		logic [10:0] pixel_x;
		logic [10:0] line_y;
		logic [10:0] rect_x;
		logic [10:0] rect_y;
		logic [7:0]  transparent_index;
		logic [7:0]  background_index;
		logic        has_transparency;
		logic        restore_background;
	} in_item_t;

	typedef struct packed {
		logic [15:0] fb_address;
		logic [7:0]  fb_byte;
		logic        wrote;
		logic        address_fault;
	} out_item_t;

	typedef struct packed {
		logic signed [10:0] origin_x;
		logic signed [10:0] origin_y;
		logic [8:0]         row_bytes;
		logic [11:0]        screen_width;
	} cfg_t;

	// One classified item as it waits in the queue.
	typedef struct packed {
		op_t                  op;
		logic [7:0]           idx;
		logic                 ink;
		logic                 pal_ok;
		logic [FB_ADDR_W-1:0] addr;
		logic [15:0]          out_addr;
		logic [7:0]           mask;
	} work_t;

endpackage

// ===== src/indexed_pixel_to_mono_framebuffer.sv =====
// Pipeline: an accepted item passes two address stages, the queue, and the framebuffer
// read stage before the modify step and the output register.
// Throughput: one item per cycle while results are taken, set by the single read and
// write port pair of the framebuffer store with forwarding of the last byte written.
// Reset: the palette reads as ink zero and a clearing pass zeroes all 65536 framebuffer
// bytes, one byte a cycle, with item_ready low; configuration writes are taken.
module indexed_pixel_to_mono_framebuffer import ipmfb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  in_item_t    item,
	output logic        result_valid,
	input  logic        result_ready,
	output out_item_t   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t  cfg_q;
	logic  cfg_we;
	logic  front_ready;
	logic  clear_busy;
	logic  fw_valid;
	logic  fw_ready;
	work_t fw_data;
	logic  bw_valid;
	logic  bw_ready;
	work_t bw_data;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x     <= '0;
			cfg_q.origin_y     <= '0;
			cfg_q.row_bytes    <= 9'd120;
			cfg_q.screen_width <= 12'd960;
		end else if (cfg_we) begin
			case (paddr[3:2])
				REG_ORIGIN_X:     cfg_q.origin_x     <= pwdata[10:0];
				REG_ORIGIN_Y:     cfg_q.origin_y     <= pwdata[10:0];
				REG_ROW_BYTES:    cfg_q.row_bytes    <= pwdata[8:0];
				REG_SCREEN_WIDTH: cfg_q.screen_width <= pwdata[11:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (paddr[3:2])
			REG_ORIGIN_X:     prdata = 32'(cfg_q.origin_x);
			REG_ORIGIN_Y:     prdata = 32'(cfg_q.origin_y);
			REG_ROW_BYTES:    prdata = {23'd0, cfg_q.row_bytes};
			REG_SCREEN_WIDTH: prdata = {20'd0, cfg_q.screen_width};
			default:          prdata = '0;
		endcase
	end

	// No transaction is taken while the framebuffer is being cleared.
	assign item_ready = front_ready && !clear_busy;

	ipmfb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid && !clear_busy),
		.item_ready (front_ready),
		.item       (item),
		.cfg        (cfg_q),
		.work_valid (fw_valid),
		.work_ready (fw_ready),
		.work       (fw_data)
	);

	ipmfb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fw_valid),
		.wr_ready (fw_ready),
		.wr_data  (fw_data),
		.rd_valid (bw_valid),
		.rd_ready (bw_ready),
		.rd_data  (bw_data)
	);

	ipmfb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.work_valid   (bw_valid),
		.work_ready   (bw_ready),
		.work         (bw_data),
		.clear_busy   (clear_busy),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== src/ipmfb_ram.sv =====
module ipmfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port; a read of the address being
	// written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/ipmfb_front.sv =====
module ipmfb_front import ipmfb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  in_item_t item,
	input  cfg_t     cfg,
	output logic     work_valid,
	input  logic     work_ready,
	output work_t    work
);

	logic                      valid_s1;
	op_t                       op_s1;
	logic [7:0]                idx_s1;
	logic                      ink_s1;
	logic                      pal_ok_s1;
	logic signed [COORD_W-1:0] col_s1;
	logic signed [COORD_W-1:0] row_s1;

	logic                     valid_s2;
	op_t                      op_s2;
	logic [7:0]               idx_s2;
	logic                     ink_s2;
	logic                     pal_ok_s2;
	logic signed [10:0]       q_s2;
	logic [7:0]               mask_s2;
	logic signed [ADDR_W-1:0] prod_s2;

	logic                      ready_s1;
	logic                      ready_s2;
	logic [6:0]                rgb_sum;
	logic                      load_ok;
	logic                      is_trans;
	logic [7:0]                pix_eff;
	logic                      skip_px;
	op_t                       op_c;
	logic signed [COORD_W-1:0] col_c;
	logic signed [COORD_W-1:0] row_c;
	logic signed [ADDR_W-1:0]  prod_c;
	logic signed [ADDR_W-1:0]  addr_c;
	logic                      fault_c;

	localparam logic signed [ADDR_W-1:0] FB_LIMIT = ADDR_W'(FB_BYTES);

	// Pipeline flow control.
	assign ready_s2   = !valid_s2 || work_ready;
	assign ready_s1   = !valid_s1 || ready_s2;
	assign item_ready = ready_s1;

	// Classify the incoming transaction and form its canvas position.
	always_comb begin
		rgb_sum  = 7'({2'b00, item.entry_color[15:11]}) + 7'({1'b0, item.entry_color[10:5]})
			+ 7'({2'b00, item.entry_color[4:0]});
		load_ok  = {1'b0, item.entry_index} < 9'(PALETTE_SIZE);
		is_trans = item.pixel_value == item.transparent_index;
		pix_eff  = (item.restore_background && is_trans) ? item.background_index
			: item.pixel_value;
		skip_px  = (!item.restore_background && item.has_transparency && is_trans)
			|| ({1'b0, item.pixel_x} >= cfg.screen_width);
		if (item.mode == MODE_LOAD) begin
			op_c = load_ok ? OP_LOAD : OP_SKIP;
		end else begin
			op_c = skip_px ? OP_SKIP : OP_DRAW;
		end
		col_c = $signed({3'b000, item.rect_x}) + $signed({3'b000, item.pixel_x})
			+ $signed({{3{cfg.origin_x[10]}}, cfg.origin_x});
		row_c = $signed({3'b000, item.rect_y}) + $signed({3'b000, item.line_y})
			+ $signed({{3{cfg.origin_y[10]}}, cfg.origin_y});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && item_valid) begin
			op_s1     <= op_c;
			idx_s1    <= (item.mode == MODE_LOAD) ? item.entry_index : pix_eff;
			ink_s1    <= rgb_sum[6];
			pal_ok_s1 <= {1'b0, pix_eff} < 9'(PALETTE_SIZE);
			col_s1    <= col_c;
			row_s1    <= row_c;
		end
	end

	// Row times row pitch, floor of the column by eight, and the bit mask.
	assign prod_c = ADDR_W'(row_s1) * ADDR_W'($signed({1'b0, cfg.row_bytes}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			op_s2     <= op_s1;
			idx_s2    <= idx_s1;
			ink_s2    <= ink_s1;
			pal_ok_s2 <= pal_ok_s1;
			q_s2      <= col_s1[COORD_W-1:3];
			mask_s2   <= 8'h80 >> col_s1[2:0];
			prod_s2   <= prod_c;
		end
	end

	// Final byte address and range check on the way into the queue.
	always_comb begin
		addr_c  = prod_s2 + ADDR_W'(q_s2);
		fault_c = addr_c[ADDR_W-1] || (addr_c >= FB_LIMIT);
		work.op       = (op_s2 == OP_DRAW && fault_c) ? OP_FAULT : op_s2;
		work.idx      = idx_s2;
		work.ink      = ink_s2;
		work.pal_ok   = pal_ok_s2;
		work.addr     = addr_c[FB_ADDR_W-1:0];
		work.out_addr = addr_c[15:0];
		work.mask     = mask_s2;
	end

	assign work_valid = valid_s2;

endmodule

// ===== src/ipmfb_queue.sv =====
module ipmfb_queue import ipmfb_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_valid,
	output logic  wr_ready,
	input  work_t wr_data,
	output logic  rd_valid,
	input  logic  rd_ready,
	output work_t rd_data
);

	work_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               push;
	logic               pop;

	assign wr_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign rd_valid = count_q != '0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = entry_q[rd_ptr_q];

	// Pointer and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== src/ipmfb_back.sv =====
module ipmfb_back import ipmfb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      work_valid,
	output logic      work_ready,
	input  work_t     work,
	output logic      clear_busy,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	logic                    valid_s3;
	work_t                   entry_s3;
	logic                    pal_vld_s3;
	logic [PALETTE_SIZE-1:0] pal_vld_q;

	logic                 lastw_v_q;
	logic [FB_ADDR_W-1:0] lastw_addr_q;
	logic [7:0]           lastw_byte_q;

	logic                 clr_busy_q;
	logic [FB_ADDR_W-1:0] clr_cnt_q;

	logic      out_v_q;
	out_item_t out_q;

	logic                  take;
	logic                  adv_s3;
	logic                  free_s3;
	logic                  pal_we;
	logic                  pal_rdata;
	logic [7:0]            fb_rdata;
	logic                  fb_we;
	logic [FB_ADDR_W-1:0]  fb_waddr;
	logic [7:0]            fb_wdata;
	logic                  ink;
	logic [7:0]            old_byte;
	logic [7:0]            new_byte;
	out_item_t             res_c;

	// Flow control: the stage moves on when the output register is free.
	assign adv_s3     = valid_s3 && (!out_v_q || result_ready);
	assign free_s3    = !valid_s3 || adv_s3;
	assign work_ready = free_s3;
	assign take       = work_valid && free_s3;
	assign pal_we     = take && (work.op == OP_LOAD);

	// Palette store; a slot never loaded since reset reads as ink zero.
	ipmfb_ram #(
		.WIDTH (1),
		.DEPTH (PALETTE_SIZE)
	) u_palette (
		.clk   (clk),
		.we    (pal_we),
		.waddr (work.idx[PAL_ADDR_W-1:0]),
		.wdata (work.ink),
		.re    (take),
		.raddr (work.idx[PAL_ADDR_W-1:0]),
		.rdata (pal_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_vld_q <= '0;
		end else if (pal_we) begin
			pal_vld_q[work.idx[PAL_ADDR_W-1:0]] <= 1'b1;
		end
	end

	// Framebuffer store, written by the clearing pass or by the modify step.
	ipmfb_ram #(
		.WIDTH (8),
		.DEPTH (FB_BYTES)
	) u_frame (
		.clk   (clk),
		.we    (fb_we),
		.waddr (fb_waddr),
		.wdata (fb_wdata),
		.re    (take),
		.raddr (work.addr),
		.rdata (fb_rdata)
	);

	// Clearing pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + FB_ADDR_W'(1);
			if (clr_cnt_q == FB_ADDR_W'(FB_BYTES - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign clear_busy = clr_busy_q;

	// Read stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (free_s3) begin
			valid_s3 <= work_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			entry_s3   <= work;
			pal_vld_s3 <= pal_vld_q[work.idx[PAL_ADDR_W-1:0]];
		end
	end

	// Modify step; the last byte written is forwarded over the stored copy.
	always_comb begin
		ink      = pal_vld_s3 && entry_s3.pal_ok && pal_rdata;
		old_byte = (lastw_v_q && lastw_addr_q == entry_s3.addr) ? lastw_byte_q : fb_rdata;
		new_byte = ink ? (old_byte | entry_s3.mask) : (old_byte & ~entry_s3.mask);
		res_c    = '0;
		case (entry_s3.op)
			OP_DRAW: begin
				res_c.fb_address = entry_s3.out_addr;
				res_c.fb_byte    = new_byte;
				res_c.wrote      = 1'b1;
			end
			OP_FAULT: begin
				res_c.address_fault = 1'b1;
			end
			default: begin
				res_c = '0;
			end
		endcase
		if (clr_busy_q) begin
			fb_we    = 1'b1;
			fb_waddr = clr_cnt_q;
			fb_wdata = 8'h00;
		end else begin
			fb_we    = adv_s3 && (entry_s3.op == OP_DRAW);
			fb_waddr = entry_s3.addr;
			fb_wdata = new_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lastw_v_q <= 1'b0;
		end else if (adv_s3 && entry_s3.op == OP_DRAW) begin
			lastw_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && entry_s3.op == OP_DRAW) begin
			lastw_addr_q <= entry_s3.addr;
			lastw_byte_q <= new_byte;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv_s3) begin
			out_v_q <= 1'b1;
		end else if (result_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			out_q <= res_c;
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

endmodule
